>>> hw/rtl/g2g_pkg.sv
// Package: widths, register indexes, CORDIC constants and angle table.
`timescale 1ns / 1ps
package g2g_pkg;
   localparam int CordicSteps = 16;
   localparam int AngleTableLen = 24;
   localparam int StepW = 5;
   localparam int CordW = 34;
   localparam logic signed [CordW-1:0] InvGainQ28 = 34'sd163008219;

   typedef enum logic [2:0] {
      REG_GOAL_X       = 3'd0,
      REG_GOAL_Y       = 3'd1,
      REG_SPEED_GAIN   = 3'd2,
      REG_TURN_GAIN    = 3'd3,
      REG_STALL_MARGIN = 3'd4
   } reg_idx_type;

   typedef logic [2:0] csr_addr_type;

   function automatic logic signed [CordW-1:0] angle_step(input logic [StepW-1:0] i);
      logic signed [CordW-1:0] r;
      r = '0;
      case (i)
         5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
         5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
         5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
         5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
         5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
         5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction
endpackage

>>> hw/rtl/go_to_goal_steering_controller_core.sv
// Go-to-goal steering controller: CORDIC rotation and bit-serial gain products.
//
//  channel | dir | word
//  req     | in  | tdata[79:0] = pos_x, pos_y, heading
//  rsp     | out | tdata[63:0] = fwd_speed, turn_rate; tuser = stall_flag
//  csr     | in  | index 3 bits, data 32 bits
//
// One pose runs through the CORDIC rotation, four shift-add products for the
// errors, the bit-serial gain products and the output state, in that order;
// one pose is in work at a time.
// Reset is synchronous and restores register defaults and clears the past errors.
// A result waits in the output register; the next pose is taken meanwhile.
`timescale 1ns / 1ps
module go_to_goal_steering_controller_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [79:0]                 req_tdata,   // pos_x, pos_y, heading
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata,   // fwd_speed, turn_rate
   output logic                        rsp_tuser,   // stall_flag
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  g2g_pkg::csr_addr_type       csr_index,
   input  logic [31:0]                 csr_data
);
   import g2g_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_CORD = 7'b0000010,
      ST_MUL  = 7'b0000100,
      ST_ERR  = 7'b0001000,
      ST_GAIN = 7'b0010000,
      ST_OUT  = 7'b0100000,
      ST_WAIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [31:0] goal_x_ff, goal_y_ff;
   logic [15:0] speed_gain_ff, turn_gain_ff, stall_margin_ff;
   logic signed [31:0] prev_fwd_ff, prev_side_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [CordW-1:0] cx_ff, cy_ff, cz_ff;
   logic [StepW-1:0] step_ff;
   logic flip_ff;
   logic [1:0] prod_ff;            // 0:c*dx 1:s*dy 2:c*dy 3:s*dx
   logic [5:0] bit_ff;
   logic signed [67:0] acc_ff;     // running product
   logic [32:0] mplr_ff;           // multiplier shift register
   logic signed [67:0] sum_f_ff, sum_s_ff;
   logic signed [31:0] ef_ff, es_ff;
   logic [3:0] gbit_ff;
   logic signed [49:0] gf_ff, gs_ff;
   logic [63:0] rsp_data_ff;
   logic rsp_user_ff, rsp_valid_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   wire req_acc = req_tvalid && req_tready;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > 68'sd2147483647) return 32'sh7fffffff;
      if (v < -68'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [32:0] mag33(input logic signed [31:0] v);
      return v[31] ? -{v[31], v} : {v[31], v};
   endfunction

   // multiplicand for the current product
   logic signed [CordW-1:0] mcand;
   always_comb begin
      case (prod_ff)
         2'd0, 2'd2: mcand = cx_ff;
         default:    mcand = cy_ff;
      endcase
   end

   logic signed [67:0] part;
   assign part = {{34{mcand[CordW-1]}}, mcand} <<< bit_ff;

   logic signed [CordW-1:0] xs, ys;
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;

   logic signed [67:0] ef_full, es_full;
   assign ef_full = (sum_f_ff + 68'sd134217728) >>> 28;
   assign es_full = (sum_s_ff + 68'sd134217728) >>> 28;

   logic signed [32:0] mf, ms, pf, ps;
   logic spin, stall;
   assign mf = mag33(ef_ff);
   assign ms = mag33(es_ff);
   assign pf = mag33(prev_fwd_ff);
   assign ps = mag33(prev_side_ff);
   assign spin = ms > mf;
   assign stall = ((pf - mf) < $signed({17'd0, stall_margin_ff}))
               && ((ps - ms) < $signed({17'd0, stall_margin_ff}));

   logic signed [49:0] gf_r, gs_r;
   assign gf_r = (gf_ff + 50'sd128) >>> 8;
   assign gs_r = (gs_ff + 50'sd128) >>> 8;

   logic [31:0] spin_w;
   assign spin_w = {9'd0, turn_gain_ff, 7'd0};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc) state_in = ST_CORD;
         ST_CORD: if (step_ff == StepW'(CordicSteps - 1)) state_in = ST_MUL;
         ST_MUL:  if (bit_ff == 6'd32 && prod_ff == 2'd3) state_in = ST_ERR;
         ST_ERR:  state_in = ST_GAIN;
         ST_GAIN: if (gbit_ff == 4'd15) state_in = ST_OUT;
         ST_OUT:  state_in = (rsp_valid_ff && !rsp_tready) ? ST_OUT : ST_IDLE;
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         goal_x_ff <= '0;
         goal_y_ff <= '0;
         speed_gain_ff <= 16'd384;
         turn_gain_ff <= 16'd512;
         stall_margin_ff <= 16'd655;
         prev_fwd_ff <= '0;
         prev_side_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               REG_GOAL_X:       goal_x_ff <= csr_data;
               REG_GOAL_Y:       goal_y_ff <= csr_data;
               REG_SPEED_GAIN:   speed_gain_ff <= csr_data[15:0];
               REG_TURN_GAIN:    turn_gain_ff <= csr_data[15:0];
               REG_STALL_MARGIN: stall_margin_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && !(rsp_valid_ff && !rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            prev_fwd_ff <= ef_ff;
            prev_side_ff <= es_ff;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: if (req_acc) begin
            dx_ff <= {goal_x_ff[31], goal_x_ff} - {req_tdata[31], req_tdata[31:0]};
            dy_ff <= {goal_y_ff[31], goal_y_ff} - {req_tdata[63], req_tdata[63:32]};
            flip_ff <= req_tdata[79] ^ req_tdata[78];
            cz_ff <= {{3{req_tdata[79] ^ req_tdata[78] ^ req_tdata[79]}},
                      req_tdata[78:64], 16'd0};
            cx_ff <= InvGainQ28;
            cy_ff <= '0;
            step_ff <= '0;
            prod_ff <= '0;
            bit_ff <= '0;
            acc_ff <= '0;
            sum_f_ff <= '0;
            sum_s_ff <= '0;
         end
         ST_CORD: begin
            logic signed [CordW-1:0] nx, ny;
            if (!cz_ff[CordW-1]) begin
               nx = cx_ff - ys;
               ny = cy_ff + xs;
               cz_ff <= cz_ff - angle_step(step_ff);
            end else begin
               nx = cx_ff + ys;
               ny = cy_ff - xs;
               cz_ff <= cz_ff + angle_step(step_ff);
            end
            step_ff <= step_ff + 1'b1;
            if (step_ff == StepW'(CordicSteps - 1)) begin
               mplr_ff <= dx_ff;
               if (flip_ff) begin
                  nx = -nx;
                  ny = -ny;
               end
            end
            cx_ff <= nx;
            cy_ff <= ny;
         end
         ST_MUL: begin
            // one multiplier bit per cycle, top bit weighs negative
            logic signed [67:0] nacc;
            nacc = acc_ff;
            if (mplr_ff[0]) nacc = (bit_ff == 6'd32) ? acc_ff - part : acc_ff + part;
            if (bit_ff == 6'd32) begin
               bit_ff <= '0;
               acc_ff <= '0;
               prod_ff <= prod_ff + 1'b1;
               case (prod_ff)
                  2'd0: begin sum_f_ff <= nacc; mplr_ff <= dy_ff; end
                  2'd1: begin sum_f_ff <= sum_f_ff + nacc; mplr_ff <= dy_ff; end
                  2'd2: begin sum_s_ff <= nacc; mplr_ff <= dx_ff; end
                  default: sum_s_ff <= sum_s_ff - nacc;
               endcase
            end else begin
               mplr_ff <= {1'b0, mplr_ff[32:1]};
               bit_ff <= bit_ff + 1'b1;
               acc_ff <= nacc;
            end
         end
         ST_ERR: begin
            ef_ff <= sat32(ef_full);
            es_ff <= sat32(es_full);
            gbit_ff <= '0;
            gf_ff <= '0;
            gs_ff <= '0;
         end
         ST_GAIN: begin
            gbit_ff <= gbit_ff + 1'b1;
            if (speed_gain_ff[gbit_ff])
               gf_ff <= gf_ff + ({{18{ef_ff[31]}}, ef_ff} <<< gbit_ff);
            if (turn_gain_ff[gbit_ff])
               gs_ff <= gs_ff + ({{18{es_ff[31]}}, es_ff} <<< gbit_ff);
         end
         ST_OUT: if (!(rsp_valid_ff && !rsp_tready)) begin
            if (spin) begin
               rsp_data_ff <= {es_ff[31] ? -spin_w : spin_w, 32'd0};
            end else begin
               rsp_data_ff <= {sat32({{18{gs_r[49]}}, gs_r}),
                               sat32({{18{gf_r[49]}}, gf_r})};
            end
            rsp_user_ff <= stall;
         end
         default: ;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_data_ff)) else $error("result changed");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state code");
endmodule

>>> bench/tb_go_to_goal_steering_controller_core.sv
// Testbench for the go-to-goal steering controller core: predicted and checked results.
`timescale 1ns / 1ps
module tb_go_to_goal_steering_controller_core;
   import g2g_pkg::*;

   typedef struct packed {
      logic signed [31:0] fwd;
      logic signed [31:0] turn;
      logic               stall;
   } steer_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_addr_type csr_index = REG_GOAL_X;
   logic [31:0] csr_data = '0;

   go_to_goal_steering_controller_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] goal_x_q, goal_y_q;
   logic [15:0] speed_gain_q, turn_gain_q, stall_margin_q;
   logic signed [63:0] last_fwd_err, last_side_err;

   logic [79:0] pose_queue[$];
   steer_cmd_type cmd_queue[$];
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   bit feeding = 1'b1;

   function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int n);
      return v >>> n;
   endfunction

   function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [63:0] abs64(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic signed [63:0] step_angle(int i);
      logic signed [63:0] t[24];
      t = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
            41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
      return t[i];
   endfunction

   function automatic steer_cmd_type predict_steering(logic [79:0] pose);
      logic signed [63:0] dx, dy, cx, sy, za, xs, ys, ef, es, v, w, margin;
      logic [31:0] ang;
      logic flip;
      steer_cmd_type r;
      dx = 64'(goal_x_q) - 64'(signed'(pose[31:0]));
      dy = 64'(goal_y_q) - 64'(signed'(pose[63:32]));
      ang = {pose[79:64], 16'h0};
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang + 32'h8000_0000;
      za = 64'(signed'(ang));
      cx = 64'sd163008219;
      sy = 0;
      for (int i = 0; i < CordicSteps && i < 24; i++) begin
         xs = floor_shift(cx, i);
         ys = floor_shift(sy, i);
         if (za >= 0) begin
            cx = cx - ys; sy = sy + xs; za = za - step_angle(i);
         end else begin
            cx = cx + ys; sy = sy - xs; za = za + step_angle(i);
         end
      end
      if (flip) begin
         cx = -cx; sy = -sy;
      end
      ef = clamp32(floor_shift(cx * dx + sy * dy + 64'sd134217728, 28));
      es = clamp32(floor_shift(cx * dy - sy * dx + 64'sd134217728, 28));
      if (abs64(es) > abs64(ef)) begin
         v = 0;
         w = 64'(turn_gain_q) * 128;
         if (es < 0) w = -w;
      end else begin
         v = clamp32(floor_shift(64'(speed_gain_q) * ef + 128, 8));
         w = clamp32(floor_shift(64'(turn_gain_q) * es + 128, 8));
      end
      margin = 64'(signed'({1'b0, stall_margin_q}));
      r.stall = (abs64(last_fwd_err) - abs64(ef) < margin) &&
                (abs64(last_side_err) - abs64(es) < margin);
      last_fwd_err = ef;
      last_side_err = es;
      r.fwd = v[31:0];
      r.turn = w[31:0];
      return r;
   endfunction

   // driver: bursts with gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            cmd_queue.push_back(predict_steering(req_tdata));
            void'(pose_queue.pop_front());
         end
         if (req_tvalid && !req_tready) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (feeding && pose_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pose_queue[0];
            if (burst_left <= 0) begin
               burst_left <= $urandom_range(1, 8);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      steer_cmd_type want;
      if (!reset) begin
         stall_phase <= stall_phase + 1;
         rsp_tready <= (stall_phase % 300 < 100) ? 1'b1 : ($urandom_range(0, 2) != 0);
         if (rsp_tvalid && rsp_tready) begin
            if (cmd_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word %h stall %b", rsp_tdata, rsp_tuser);
            end else begin
               want = cmd_queue.pop_front();
               if (rsp_tdata[31:0] !== want.fwd || rsp_tdata[63:32] !== want.turn ||
                   rsp_tuser !== want.stall) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch exp fwd %h turn %h stall %b got fwd %h turn %h stall %b",
                        want.fwd, want.turn, want.stall, rsp_tdata[31:0], rsp_tdata[63:32],
                        rsp_tuser);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles > 20000) begin
         $display("FAIL go_to_goal_steering_controller_core");
         $finish;
      end
   end

   task automatic write_csr(reg_idx_type idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_GOAL_X:       goal_x_q = value;
         REG_GOAL_Y:       goal_y_q = value;
         REG_SPEED_GAIN:   speed_gain_q = value[15:0];
         REG_TURN_GAIN:    turn_gain_q = value[15:0];
         REG_STALL_MARGIN: stall_margin_q = value[15:0];
         default: ;
      endcase
   endtask

   task automatic drain_results();
      while (pose_queue.size() != 0 || req_tvalid || cmd_queue.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
         default: return 32'(signed'($urandom_range(0, 2000 << 16)) - (1000 << 16));
      endcase
   endfunction

   task automatic approach_run(int n);
      logic signed [31:0] px, py;
      logic [15:0] h;
      px = rand_coord();
      py = rand_coord();
      h = $urandom();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            pose_queue.push_back({16'($urandom()), $urandom(), $urandom()});
         end else begin
            px = px + (goal_x_q - px) / 8 + 32'(signed'($urandom_range(0, 2000)) - 1000);
            py = py + (goal_y_q - py) / 8 + 32'(signed'($urandom_range(0, 2000)) - 1000);
            h = h + 16'($urandom_range(0, 4000)) - 16'd2000;
            pose_queue.push_back({h, py, px});
         end
      end
   endtask

   initial begin
      goal_x_q = 0; goal_y_q = 0;
      speed_gain_q = 384; turn_gain_q = 512; stall_margin_q = 655;
      last_fwd_err = 0; last_side_err = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (300) @(posedge clock);

      // directed poses at reset defaults, then extremes
      pose_queue.push_back({16'h0000, 32'h0000_0000, 32'h0000_0000});
      pose_queue.push_back({16'h4000, 32'h0001_0000, 32'h0000_0000});
      pose_queue.push_back({16'h8000, 32'h0000_0000, 32'hFFFF_0000});
      pose_queue.push_back({16'hC000, 32'h0000_0000, 32'h0000_0000});
      pose_queue.push_back({16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      pose_queue.push_back({16'h3FFF, 32'h7FFF_FFFF, 32'h8000_0000});
      pose_queue.push_back({16'h2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      pose_queue.push_back({16'h2000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      pose_queue.push_back({16'h6000, 32'h0000_1000, 32'h0000_2000});
      drain_results();

      write_csr(REG_GOAL_X, 32'h7FFF_FFFF);
      write_csr(REG_GOAL_Y, 32'h8000_0000);
      write_csr(REG_SPEED_GAIN, 32'h0000_FFFF);
      write_csr(REG_TURN_GAIN, 32'h0000_FFFF);
      write_csr(REG_STALL_MARGIN, 32'h0000_0000);
      pose_queue.push_back({16'h0000, 32'h7FFF_FFFF, 32'h8000_0000});
      pose_queue.push_back({16'h5555, 32'h0000_0000, 32'h0000_0000});
      pose_queue.push_back({16'hE000, 32'h8000_0000, 32'h7FFF_FFFF});
      pose_queue.push_back({16'h1234, 32'h1234_5678, 32'h9ABC_DEF0});
      drain_results();

      write_csr(REG_GOAL_X, 32'h0000_0000);
      write_csr(REG_GOAL_Y, 32'h0000_0000);
      write_csr(REG_SPEED_GAIN, 32'h0000_0000);
      write_csr(REG_TURN_GAIN, 32'h0000_0000);
      write_csr(REG_STALL_MARGIN, 32'h0000_FFFF);
      pose_queue.push_back({16'h4000, 32'h0000_0000, 32'h0010_0000});
      pose_queue.push_back({16'h0000, 32'h0000_0000, 32'h0010_0000});
      drain_results();

      for (int ph = 0; ph < 8; ph++) begin
         write_csr(REG_GOAL_X, rand_coord());
         write_csr(REG_GOAL_Y, rand_coord());
         write_csr(REG_SPEED_GAIN, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1024));
         write_csr(REG_TURN_GAIN, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1024));
         write_csr(REG_STALL_MARGIN, $urandom());
         for (int k = 0; k < 10; k++) approach_run($urandom_range(10, 30));
         drain_results();
      end

      feeding = 1'b0;
      if (mismatch_count == 0)
         $display("PASS go_to_goal_steering_controller_core");
      else
         $display("FAIL go_to_goal_steering_controller_core");
      $finish;
   end
endmodule
